FILE: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Payload structs, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned WordW        = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned StatW        = 2;

  // command codes
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CmdW-1:0] CMD_LIST       = 3'd4;

  // status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] value_res;
    logic [StatW-1:0] status;
    logic             last;
  } out_item_t;

  // pointer/store update requested by the controller
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_PUSH_FRONT,
    UPD_PUSH_BACK,
    UPD_POP_FRONT,
    UPD_POP_BACK
  } upd_e;

  // source of the next output register load
  typedef enum logic [1:0] {
    OUT_HOLD,
    OUT_STATUS,
    OUT_PEND,
    OUT_LIST
  } out_sel_e;

  typedef struct packed {
    upd_e             upd;
    logic             list_first;
    logic             list_next;
    out_sel_e         out_sel;
    logic             pend_load;
    logic [StatW-1:0] status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl: command sequencer
// Decodes commands, picks status, steps listings and output register loads.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [dq_pkg::CmdW-1:0]  command_i,
  input  wire dq_pkg::dp_stat_t         stat_i,
  output dq_pkg::ctrl_cmd_t             cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HOLD = 2'd1;  // status result waits for output reg
  localparam logic [1:0] S_LIST = 2'd2;  // streaming entries

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{upd: dq_pkg::UPD_NONE, list_first: 1'b0, list_next: 1'b0,
                out_sel: dq_pkg::OUT_HOLD, pend_load: 1'b0, status: dq_pkg::ST_OK};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((command_i == dq_pkg::CMD_LIST) && !stat_i.empty) begin
            cmd_o.list_first = 1'b1;
            state_d          = S_LIST;
          end else begin
            case (command_i)
              dq_pkg::CMD_PUSH_FRONT: begin
                if (stat_i.full) cmd_o.status = dq_pkg::ST_FULL;
                else cmd_o.upd = dq_pkg::UPD_PUSH_FRONT;
              end
              dq_pkg::CMD_PUSH_BACK: begin
                if (stat_i.full) cmd_o.status = dq_pkg::ST_FULL;
                else cmd_o.upd = dq_pkg::UPD_PUSH_BACK;
              end
              dq_pkg::CMD_POP_FRONT: begin
                if (stat_i.empty) cmd_o.status = dq_pkg::ST_EMPTY;
                else cmd_o.upd = dq_pkg::UPD_POP_FRONT;
              end
              dq_pkg::CMD_POP_BACK: begin
                if (stat_i.empty) cmd_o.status = dq_pkg::ST_EMPTY;
                else cmd_o.upd = dq_pkg::UPD_POP_BACK;
              end
              dq_pkg::CMD_LIST: begin
                cmd_o.status = dq_pkg::ST_EMPTY;
              end
              default: begin
                cmd_o.status = dq_pkg::ST_OK;
              end
            endcase
            if (stat_i.out_free) begin
              cmd_o.out_sel = dq_pkg::OUT_STATUS;
            end else begin
              cmd_o.pend_load = 1'b1;
              state_d         = S_HOLD;
            end
          end
        end
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          cmd_o.out_sel = dq_pkg::OUT_PEND;
          state_d       = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat_i.out_free) begin
          cmd_o.out_sel = dq_pkg::OUT_LIST;
          if (stat_i.list_last) state_d = S_IDLE;
          else cmd_o.list_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a listing only runs over a non-empty queue
  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> !stat_i.empty)
    else $error("listing on empty queue");

  // nothing accepted while a listing or held status is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST || state_q == S_HOLD) |-> !accept)
    else $error("accept while busy");

endmodule

`default_nettype wire

FILE: src/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath: ring store, pointers and output register
// Front index, entry count, listing cursor, held status and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_dpath #(
  parameter int unsigned Depth = dq_pkg::DepthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [dq_pkg::WordW-1:0]  value_i,
  input  wire dq_pkg::ctrl_cmd_t         cmd_i,
  output dq_pkg::dp_stat_t               stat_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output dq_pkg::out_item_t              out_item_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW:0]   DepthX   = (IdxW + 1)'(Depth);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] DepthC   = CntW'(Depth);

  logic [IdxW-1:0]          front_q, front_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [IdxW-1:0]          k_q, k_d;
  logic [dq_pkg::StatW-1:0] pend_q;
  logic                     out_valid_q, out_valid_d;
  dq_pkg::out_item_t        out_q, out_d;

  logic [IdxW:0]            back_sum, rd_sum;
  logic [IdxW-1:0]          back_slot, rd_slot, front_dec, front_inc;
  logic                     we, re;
  logic [IdxW-1:0]          waddr, raddr;
  logic [dq_pkg::WordW-1:0] rdata;
  logic                     is_push, is_pop;

  // ring arithmetic: sums stay below twice the depth
  always_comb begin
    back_sum  = {1'b0, front_q} + {1'b0, count_q[IdxW-1:0]};
    back_slot = (back_sum >= DepthX) ? IdxW'(back_sum - DepthX) : back_sum[IdxW-1:0];
    rd_sum    = {1'b0, front_q} + {1'b0, k_q} + (IdxW + 1)'(1);
    rd_slot   = (rd_sum >= DepthX) ? IdxW'(rd_sum - DepthX) : rd_sum[IdxW-1:0];
    front_dec = (front_q == '0) ? LastSlot : front_q - IdxW'(1);
    front_inc = (front_q == LastSlot) ? '0 : front_q + IdxW'(1);
  end

  assign is_push = (cmd_i.upd == dq_pkg::UPD_PUSH_FRONT) ||
                   (cmd_i.upd == dq_pkg::UPD_PUSH_BACK);
  assign is_pop  = (cmd_i.upd == dq_pkg::UPD_POP_FRONT) ||
                   (cmd_i.upd == dq_pkg::UPD_POP_BACK);

  assign we    = is_push;
  assign waddr = (cmd_i.upd == dq_pkg::UPD_PUSH_FRONT) ? front_dec : back_slot;
  assign re    = cmd_i.list_first || cmd_i.list_next;
  assign raddr = cmd_i.list_first ? front_q : rd_slot;

  dq_ram #(
    .Width (dq_pkg::WordW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == DepthC);
  assign stat_o.list_last = ((CntW'(k_q) + CntW'(1)) == count_q);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    k_d     = k_q;
    case (cmd_i.upd)
      dq_pkg::UPD_PUSH_FRONT: begin
        front_d = front_dec;
        count_d = count_q + CntW'(1);
      end
      dq_pkg::UPD_PUSH_BACK: count_d = count_q + CntW'(1);
      dq_pkg::UPD_POP_FRONT: begin
        front_d = front_inc;
        count_d = count_q - CntW'(1);
      end
      dq_pkg::UPD_POP_BACK: count_d = count_q - CntW'(1);
      default: ;
    endcase
    if (cmd_i.list_first) k_d = '0;
    else if (cmd_i.list_next) k_d = k_q + IdxW'(1);
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (cmd_i.out_sel)
      dq_pkg::OUT_STATUS: begin
        out_d       = '{value_res: '0, status: cmd_i.status, last: 1'b1};
        out_valid_d = 1'b1;
      end
      dq_pkg::OUT_PEND: begin
        out_d       = '{value_res: '0, status: pend_q, last: 1'b1};
        out_valid_d = 1'b1;
      end
      dq_pkg::OUT_LIST: begin
        out_d       = '{value_res: rdata, status: dq_pkg::ST_OK,
                        last: stat_o.list_last};
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.pend_load) pend_q <= cmd_i.status;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_push |-> !stat_o.full)
    else $error("push into full store");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_pop |-> !stat_o.empty)
    else $error("pop from empty store");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_sel != dq_pkg::OUT_HOLD) |-> stat_o.out_free)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

FILE: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit words
// Push/pop at either end, or stream all entries front to back.
// ----------------------------------------------------------------------------
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+--------------------------------
//   input    | in_valid_i   | in_stall_o   | in_item_i  (command, value)
//   output   | out_valid_o  | out_stall_i  | out_item_o (value_res, status, last)
//
// Push, pop and unused commands: one status transaction each.
// Listing: first entry via the RAM read register and output register, then one
//   entry per cycle unless stalled; the single RAM read port sets this rate.
// Reset clears front index, count and output valid; store contents are left.
// A stalled output holds one status in a side register while the next command
//   is already taken; further commands wait until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned Depth = dq_pkg::DepthDefault  // 2..64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dq_pkg::in_item_t  in_item_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dq_pkg::out_item_t      out_item_o
);

  // controller -> datapath commands, datapath -> controller status
  dq_pkg::ctrl_cmd_t ctrl_cmd;
  dq_pkg::dp_stat_t  dp_stat;

  // sequencer: decode, status choice, listing steps
  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (in_item_i.command),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // ring store, pointers and result register
  dq_dpath #(
    .Depth (Depth)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_item_i.value),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
